// ===== rtl/request_tag_tracker_timeout_retry_assert.svh =====
// Assertion macros used by the checker file.
`ifndef REQUEST_TAG_TRACKER_TIMEOUT_RETRY_ASSERT_SVH
`define REQUEST_TAG_TRACKER_TIMEOUT_RETRY_ASSERT_SVH

// Same-cycle implication, off during reset.
`define RTTR_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rttr check failed");

// Next-cycle implication, off during reset.
`define RTTR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rttr check failed");

`endif

// ===== rtl/rttr_pkg.sv =====
`default_nettype none
package rttr_pkg;

   // sizes
   localparam int DEF_ENTRIES = 256;
   localparam int QUEUE_DEPTH = 2;
   localparam int LINK_W      = 9;

   typedef logic [LINK_W-1:0] link_type;
   localparam link_type NULL_LINK = 9'h1FF;

   // request functions
   localparam logic [2:0] FUNC_ENQUEUE  = 3'd0;
   localparam logic [2:0] FUNC_ISSUE    = 3'd1;
   localparam logic [2:0] FUNC_TIMEOUT  = 3'd2;
   localparam logic [2:0] FUNC_RESPONSE = 3'd3;
   localparam logic [2:0] FUNC_RETRIEVE = 3'd4;

   // result status codes
   localparam logic [3:0] STATUS_OK         = 4'd0;
   localparam logic [3:0] STATUS_FULL       = 4'd1;
   localparam logic [3:0] STATUS_NONE_READY = 4'd2;
   localparam logic [3:0] STATUS_TIMEOUT    = 4'd3;
   localparam logic [3:0] STATUS_DEV_ERROR  = 4'd4;
   localparam logic [3:0] STATUS_SEND_FAIL  = 4'd5;
   localparam logic [3:0] STATUS_DROPPED    = 4'd6;
   localparam logic [3:0] STATUS_PUSH       = 4'd7;
   localparam logic [3:0] STATUS_NO_EXPIRY  = 4'd8;
   localparam logic [3:0] STATUS_RETRIED    = 4'd9;

   // tag states, also list head index
   localparam logic [1:0] ES_FREE     = 2'd0;
   localparam logic [1:0] ES_READY    = 2'd1;
   localparam logic [1:0] ES_SENT     = 2'd2;
   localparam logic [1:0] ES_ANSWERED = 2'd3;

   // control register indexes
   localparam logic [1:0] CSR_TIMEOUT    = 2'd0;
   localparam logic [1:0] CSR_RETRY      = 2'd1;
   localparam logic [1:0] CSR_ERROR_TYPE = 2'd2;
   localparam logic [1:0] CSR_PUSH_TYPE  = 2'd3;

   localparam logic [15:0] RST_TIMEOUT    = 16'd10;
   localparam logic [3:0]  RST_RETRY      = 4'd1;
   localparam logic [7:0]  RST_ERROR_TYPE = 8'd0;
   localparam logic [7:0]  RST_PUSH_TYPE  = 8'd1;

   typedef struct packed {
      logic [15:0] timeout_seconds;
      logic [3:0]  retry_limit;
      logic [7:0]  error_type_code;
      logic [7:0]  push_type_code;
   } cfg_type;

   typedef struct packed {
      logic [2:0]  func;
      logic [7:0]  tag;
      logic [7:0]  msg_type;
      logic [15:0] request_length;
      logic [15:0] response_max;
      logic [15:0] bytes_received;
      logic        send_ok;
      logic [31:0] now_seconds;
   } req_type;

   typedef struct packed {
      logic [3:0]  status;
      logic [7:0]  result_tag;
      logic [7:0]  issued_type;
      logic [15:0] out_request_length;
      logic [15:0] data_length;
      logic        truncated;
   } rsp_type;

   typedef enum logic [2:0] {
      OP_ENQ, OP_ISSUE, OP_TMO, OP_ARR, OP_RET, OP_BAD
   } op_type;

   // classified beat handed from front to back
   typedef struct packed {
      op_type  op;
      logic    tag_ok;
      req_type req;
   } item_type;

endpackage
`default_nettype wire

// ===== rtl/request_tag_tracker_timeout_retry.sv =====
// Channel   Ports                          Moves
// request   req_valid/req_stall/req_data   one command beat in
// response  rsp_valid/rsp_stall/rsp_data   one result beat out per command
// control   csr_we/csr_index/csr_wdata     register write, no wait
//
// Back end per command: settled at once (full, nothing to issue, no sent entry, push,
// tag out of range, unknown func), settled after its entry read, or, if a tag moves,
// read, decide, unlink, relink, new head, result beat; a timeout check also reads
// each sent entry it steps over in turn. The single-port tag tables set these steps.
// Reset is synchronous, then a clearing pass over all ENTRIES tags rebuilds the lists.
// A two-beat queue takes commands while the back end or the result stalls.
`default_nettype none
module request_tag_tracker_timeout_retry #(
   parameter int ENTRIES = rttr_pkg::DEF_ENTRIES
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire rttr_pkg::req_type  req_data,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output rttr_pkg::rsp_type       rsp_data,
   input  wire logic               csr_we,
   input  wire logic [1:0]         csr_index,
   input  wire logic [15:0]        csr_wdata
);
   rttr_pkg::cfg_type  cfg_ff;
   rttr_pkg::item_type q_item;
   logic               q_valid, q_pop;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.timeout_seconds <= rttr_pkg::RST_TIMEOUT;
         cfg_ff.retry_limit     <= rttr_pkg::RST_RETRY;
         cfg_ff.error_type_code <= rttr_pkg::RST_ERROR_TYPE;
         cfg_ff.push_type_code  <= rttr_pkg::RST_PUSH_TYPE;
      end else if (csr_we) begin
         case (csr_index)
            rttr_pkg::CSR_TIMEOUT:    cfg_ff.timeout_seconds <= csr_wdata;
            rttr_pkg::CSR_RETRY:      cfg_ff.retry_limit     <= csr_wdata[3:0];
            rttr_pkg::CSR_ERROR_TYPE: cfg_ff.error_type_code <= csr_wdata[7:0];
            rttr_pkg::CSR_PUSH_TYPE:  cfg_ff.push_type_code  <= csr_wdata[7:0];
            default:                  cfg_ff <= cfg_ff;
         endcase
      end
   end

   rttr_front #(.ENTRIES(ENTRIES)) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_valid   (q_valid),
      .q_item    (q_item),
      .q_pop     (q_pop)
   );

   rttr_back #(.ENTRIES(ENTRIES)) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_valid   (q_valid),
      .q_item    (q_item),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .rsp_stall (rsp_stall)
   );

endmodule
`default_nettype wire

// ===== rtl/rttr_front.sv =====
`default_nettype none
module rttr_front #(
   parameter int ENTRIES = rttr_pkg::DEF_ENTRIES
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire rttr_pkg::req_type  req_data,
   output logic                    q_valid,
   output rttr_pkg::item_type      q_item,
   input  wire logic               q_pop
);
   localparam int QD = rttr_pkg::QUEUE_DEPTH;
   localparam int QW = $clog2(QD);
   localparam logic [8:0] LIMIT = 9'(ENTRIES);

   rttr_pkg::item_type item_c;
   rttr_pkg::item_type queue_mem [QD];
   logic [QW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QW:0]   count_ff, count_in;
   logic          push;

   // classify the request
   always_comb begin
      item_c.req    = req_data;
      item_c.tag_ok = {1'b0, req_data.tag} < LIMIT;
      case (req_data.func)
         rttr_pkg::FUNC_ENQUEUE:  item_c.op = rttr_pkg::OP_ENQ;
         rttr_pkg::FUNC_ISSUE:    item_c.op = rttr_pkg::OP_ISSUE;
         rttr_pkg::FUNC_TIMEOUT:  item_c.op = rttr_pkg::OP_TMO;
         rttr_pkg::FUNC_RESPONSE: item_c.op = rttr_pkg::OP_ARR;
         rttr_pkg::FUNC_RETRIEVE: item_c.op = rttr_pkg::OP_RET;
         default:                 item_c.op = rttr_pkg::OP_BAD;
      endcase
   end

   assign req_stall = (count_ff == (QW+1)'(QD));
   assign push      = req_valid && !req_stall;
   assign q_valid   = (count_ff != '0);
   assign q_item    = queue_mem[rd_ptr_ff];

   // queue pointers
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QW'(QD-1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (q_pop) begin
         rd_ptr_in = (rd_ptr_ff == QW'(QD-1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !q_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && q_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         queue_mem[wr_ptr_ff] <= item_c;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/rttr_back.sv =====
`default_nettype none
module rttr_back #(
   parameter int ENTRIES = rttr_pkg::DEF_ENTRIES
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire rttr_pkg::cfg_type  cfg,
   input  wire logic               q_valid,
   input  wire rttr_pkg::item_type q_item,
   output logic                    q_pop,
   output logic                    rsp_valid,
   output rttr_pkg::rsp_type       rsp_data,
   input  wire logic               rsp_stall
);
   localparam int AW = $clog2(ENTRIES);
   localparam rttr_pkg::link_type LIMIT = 9'(ENTRIES);
   localparam rttr_pkg::link_type LAST  = 9'(ENTRIES-1);

   typedef enum logic [2:0] {
      S_CLEAR, S_IDLE, S_EVAL, S_UNLINK, S_LINK, S_HEAD
   } state_type;

   function automatic logic link_ok(input rttr_pkg::link_type l);
      return l < LIMIT;
   endfunction

   function automatic rttr_pkg::link_type def_next(input logic [AW-1:0] a);
      rttr_pkg::link_type ax;
      ax = 9'(a);
      return (ax == LAST) ? rttr_pkg::NULL_LINK : ax + 9'd1;
   endfunction

   function automatic rttr_pkg::link_type def_prev(input logic [AW-1:0] a);
      rttr_pkg::link_type ax;
      ax = 9'(a);
      return (ax == '0) ? rttr_pkg::NULL_LINK : ax - 9'd1;
   endfunction

   // per-tag stores
   logic [1:0]          state_mem [ENTRIES];
   rttr_pkg::link_type  next_mem  [ENTRIES];
   rttr_pkg::link_type  prev_mem  [ENTRIES];
   logic [7:0]          type_mem  [ENTRIES];
   logic [15:0]         rlen_mem  [ENTRIES];
   logic [15:0]         rmax_mem  [ENTRIES];
   logic [15:0]         dlen_mem  [ENTRIES];
   logic [31:0]         time_mem  [ENTRIES];
   logic [3:0]          retry_mem [ENTRIES];
   logic                err_mem   [ENTRIES];
   logic                trunc_mem [ENTRIES];

   // registered read port
   logic [AW-1:0]       rd_addr;
   logic [1:0]          st_rd_ff;
   rttr_pkg::link_type  nx_rd_ff, pv_rd_ff;
   logic [7:0]          ty_rd_ff;
   logic [15:0]         rl_rd_ff, rm_rd_ff, dl_rd_ff;
   logic [31:0]         tm_rd_ff;
   logic [3:0]          rt_rd_ff;
   logic                er_rd_ff, tr_rd_ff;
   logic [1:0]          cur_state;
   rttr_pkg::link_type  cur_next, cur_prev;

   // write ports
   logic                nx_we, pv_we, st_we, enq_we, ty_we, dl_we, tm_we, rt_we, er_we, tr_we;
   logic [AW-1:0]       nx_wa, pv_wa;
   rttr_pkg::link_type  nx_wd, pv_wd;
   logic [15:0]         dl_wd;
   logic [3:0]          rt_wd;
   logic                er_wd, tr_wd;

   // sequencer
   state_type           state_ff, state_in;
   rttr_pkg::item_type  item_ff, item_in;
   logic [AW-1:0]       e_ff, e_in;
   logic [1:0]          from_ff, from_in, to_ff, to_in;
   rttr_pkg::link_type  p_ff, p_in, n_ff, n_in;
   rttr_pkg::link_type  heads_ff [4];
   rttr_pkg::link_type  heads_in [4];
   rttr_pkg::rsp_type   res_ff, res_in, rsp_data_ff, rsp_data_in;
   logic                rsp_valid_ff, rsp_valid_in, done;
   rttr_pkg::link_type  h;
   logic [31:0]         age;
   logic                expired;
   logic [15:0]         copy;

   assign cur_state = st_rd_ff;
   assign cur_next  = nx_rd_ff;
   assign cur_prev  = pv_rd_ff;

   // expiry test and response clamp
   assign age     = item_ff.req.now_seconds - tm_rd_ff;
   assign expired = (item_ff.req.now_seconds > tm_rd_ff) &&
                    (age > {16'd0, cfg.timeout_seconds});
   assign copy    = (item_ff.req.bytes_received < rm_rd_ff) ?
                    item_ff.req.bytes_received : rm_rd_ff;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      e_in         = e_ff;
      from_in      = from_ff;
      to_in        = to_ff;
      p_in         = p_ff;
      n_in         = n_ff;
      res_in       = res_ff;
      heads_in     = heads_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      q_pop        = 1'b0;
      done         = 1'b0;
      rd_addr      = e_ff;
      h            = heads_ff[to_ff];
      nx_we = 1'b0; nx_wa = e_ff; nx_wd = rttr_pkg::NULL_LINK;
      pv_we = 1'b0; pv_wa = e_ff; pv_wd = rttr_pkg::NULL_LINK;
      st_we = 1'b0; enq_we = 1'b0; ty_we = 1'b0; dl_we = 1'b0; tm_we = 1'b0;
      rt_we = 1'b0; er_we = 1'b0; tr_we = 1'b0;
      dl_wd = '0; rt_wd = cfg.retry_limit; er_wd = 1'b0; tr_wd = 1'b0;

      case (state_ff)
         // after reset: one tag per cycle back to free, chained in order
         S_CLEAR: begin
            st_we = 1'b1;
            nx_we = 1'b1;
            nx_wd = def_next(e_ff);
            pv_we = 1'b1;
            pv_wd = def_prev(e_ff);
            e_in  = e_ff + 1'b1;
            if (e_ff == LAST[AW-1:0]) begin
               e_in     = '0;
               state_in = S_IDLE;
            end
         end

         // take one beat, settle trivial answers at once
         S_IDLE: begin
            if (q_valid && !rsp_valid_ff) begin
               q_pop   = 1'b1;
               item_in = q_item;
               res_in  = '0;
               case (q_item.op)
                  rttr_pkg::OP_ENQ: begin
                     if (link_ok(heads_ff[rttr_pkg::ES_FREE])) begin
                        e_in     = heads_ff[rttr_pkg::ES_FREE][AW-1:0];
                        state_in = S_EVAL;
                     end else begin
                        res_in.status = rttr_pkg::STATUS_FULL;
                        done          = 1'b1;
                     end
                  end
                  rttr_pkg::OP_ISSUE: begin
                     if (link_ok(heads_ff[rttr_pkg::ES_READY])) begin
                        e_in     = heads_ff[rttr_pkg::ES_READY][AW-1:0];
                        state_in = S_EVAL;
                     end else begin
                        res_in.status = rttr_pkg::STATUS_NONE_READY;
                        done          = 1'b1;
                     end
                  end
                  rttr_pkg::OP_TMO: begin
                     if (link_ok(heads_ff[rttr_pkg::ES_SENT])) begin
                        e_in     = heads_ff[rttr_pkg::ES_SENT][AW-1:0];
                        state_in = S_EVAL;
                     end else begin
                        res_in.status = rttr_pkg::STATUS_NO_EXPIRY;
                        done          = 1'b1;
                     end
                  end
                  rttr_pkg::OP_ARR: begin
                     res_in.result_tag = q_item.req.tag;
                     if (q_item.req.msg_type == cfg.push_type_code) begin
                        res_in.status      = rttr_pkg::STATUS_PUSH;
                        res_in.data_length = q_item.req.bytes_received;
                        done               = 1'b1;
                     end else if (!q_item.tag_ok) begin
                        res_in.status = rttr_pkg::STATUS_DROPPED;
                        done          = 1'b1;
                     end else begin
                        e_in     = q_item.req.tag[AW-1:0];
                        state_in = S_EVAL;
                     end
                  end
                  rttr_pkg::OP_RET: begin
                     res_in.result_tag = q_item.req.tag;
                     if (!q_item.tag_ok) begin
                        res_in.status = rttr_pkg::STATUS_NONE_READY;
                        done          = 1'b1;
                     end else begin
                        e_in     = q_item.req.tag[AW-1:0];
                        state_in = S_EVAL;
                     end
                  end
                  default: begin
                     res_in.status = rttr_pkg::STATUS_DROPPED;
                     done          = 1'b1;
                  end
               endcase
               rd_addr = e_in;
            end
         end

         // entry data is in: decide, update fields, start the list move
         S_EVAL: begin
            p_in = cur_prev;
            n_in = cur_next;
            case (item_ff.op)
               rttr_pkg::OP_ENQ: begin
                  enq_we = 1'b1; ty_we = 1'b1; dl_we = 1'b1; rt_we = 1'b1;
                  er_we  = 1'b1; tr_we = 1'b1;
                  res_in.status     = rttr_pkg::STATUS_OK;
                  res_in.result_tag = 8'(e_ff);
                  from_in  = rttr_pkg::ES_FREE;
                  to_in    = rttr_pkg::ES_READY;
                  state_in = S_UNLINK;
               end
               rttr_pkg::OP_ISSUE: begin
                  res_in.result_tag         = 8'(e_ff);
                  res_in.issued_type        = ty_rd_ff;
                  res_in.out_request_length = rl_rd_ff;
                  if (item_ff.req.send_ok) begin
                     tm_we         = 1'b1;
                     res_in.status = rttr_pkg::STATUS_OK;
                     from_in       = rttr_pkg::ES_READY;
                     to_in         = rttr_pkg::ES_SENT;
                     state_in      = S_UNLINK;
                  end else begin
                     res_in.status = rttr_pkg::STATUS_SEND_FAIL;
                     done          = 1'b1;
                  end
               end
               rttr_pkg::OP_TMO: begin
                  if (expired) begin
                     res_in.result_tag = 8'(e_ff);
                     from_in           = rttr_pkg::ES_SENT;
                     state_in          = S_UNLINK;
                     if (rt_rd_ff == '0) begin
                        er_we         = 1'b1;
                        er_wd         = 1'b1;
                        res_in.status = rttr_pkg::STATUS_TIMEOUT;
                        to_in         = rttr_pkg::ES_ANSWERED;
                     end else begin
                        rt_we         = 1'b1;
                        rt_wd         = rt_rd_ff - 4'd1;
                        res_in.status = rttr_pkg::STATUS_RETRIED;
                        to_in         = rttr_pkg::ES_READY;
                     end
                  end else if (link_ok(cur_next)) begin
                     // walk on: one sent entry per cycle
                     e_in    = cur_next[AW-1:0];
                     rd_addr = e_in;
                  end else begin
                     res_in.status = rttr_pkg::STATUS_NO_EXPIRY;
                     done          = 1'b1;
                  end
               end
               rttr_pkg::OP_ARR: begin
                  if (cur_state != rttr_pkg::ES_SENT) begin
                     res_in.status = rttr_pkg::STATUS_DROPPED;
                     done          = 1'b1;
                  end else begin
                     ty_we = 1'b1; dl_we = 1'b1; tr_we = 1'b1;
                     dl_wd = copy;
                     tr_wd = (copy < item_ff.req.bytes_received);
                     res_in.status      = rttr_pkg::STATUS_OK;
                     res_in.data_length = copy;
                     res_in.truncated   = tr_wd;
                     from_in  = rttr_pkg::ES_SENT;
                     to_in    = rttr_pkg::ES_ANSWERED;
                     state_in = S_UNLINK;
                  end
               end
               rttr_pkg::OP_RET: begin
                  if (cur_state != rttr_pkg::ES_ANSWERED) begin
                     res_in.status = rttr_pkg::STATUS_NONE_READY;
                     done          = 1'b1;
                  end else begin
                     res_in.data_length = dl_rd_ff;
                     res_in.truncated   = tr_rd_ff;
                     if (ty_rd_ff == cfg.error_type_code) begin
                        res_in.status = rttr_pkg::STATUS_DEV_ERROR;
                     end else if (er_rd_ff) begin
                        res_in.status = rttr_pkg::STATUS_TIMEOUT;
                     end else begin
                        res_in.status = rttr_pkg::STATUS_OK;
                     end
                     from_in  = rttr_pkg::ES_ANSWERED;
                     to_in    = rttr_pkg::ES_FREE;
                     state_in = S_UNLINK;
                  end
               end
               default: begin
                  res_in.status = rttr_pkg::STATUS_DROPPED;
                  done          = 1'b1;
               end
            endcase
         end

         // unlink from the old list
         S_UNLINK: begin
            if (link_ok(p_ff)) begin
               nx_we = 1'b1;
               nx_wa = p_ff[AW-1:0];
               nx_wd = n_ff;
            end else begin
               heads_in[from_ff] = n_ff;
            end
            if (link_ok(n_ff)) begin
               pv_we = 1'b1;
               pv_wa = n_ff[AW-1:0];
               pv_wd = p_ff;
            end
            state_in = S_LINK;
         end

         // point entry at the new list head, back-link the old head
         S_LINK: begin
            nx_we = 1'b1;
            nx_wa = e_ff;
            nx_wd = h;
            if (link_ok(h)) begin
               pv_we = 1'b1;
               pv_wa = h[AW-1:0];
               pv_wd = 9'(e_ff);
            end
            state_in = S_HEAD;
         end

         // entry becomes head of the new list
         S_HEAD: begin
            pv_we  = 1'b1;
            pv_wa  = e_ff;
            pv_wd  = rttr_pkg::NULL_LINK;
            st_we  = 1'b1;
            heads_in[to_ff] = 9'(e_ff);
            done   = 1'b1;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (done) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res_in;
         state_in     = S_IDLE;
      end
   end

   // sequencer state and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
         e_ff         <= '0;
         to_ff        <= rttr_pkg::ES_FREE;
         heads_ff[rttr_pkg::ES_FREE]     <= '0;
         heads_ff[rttr_pkg::ES_READY]    <= rttr_pkg::NULL_LINK;
         heads_ff[rttr_pkg::ES_SENT]     <= rttr_pkg::NULL_LINK;
         heads_ff[rttr_pkg::ES_ANSWERED] <= rttr_pkg::NULL_LINK;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         e_ff         <= e_in;
         to_ff        <= to_in;
         heads_ff     <= heads_in;
      end
      item_ff     <= item_in;
      from_ff     <= from_in;
      p_ff        <= p_in;
      n_ff        <= n_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   // memory writes and registered reads
   always_ff @(posedge clock) begin
      if (st_we)  state_mem[e_ff] <= to_ff;
      if (nx_we)  next_mem[nx_wa] <= nx_wd;
      if (pv_we)  prev_mem[pv_wa] <= pv_wd;
      if (ty_we)  type_mem[e_ff]  <= item_ff.req.msg_type;
      if (enq_we) rlen_mem[e_ff]  <= item_ff.req.request_length;
      if (enq_we) rmax_mem[e_ff]  <= item_ff.req.response_max;
      if (dl_we)  dlen_mem[e_ff]  <= dl_wd;
      if (tm_we)  time_mem[e_ff]  <= item_ff.req.now_seconds;
      if (rt_we)  retry_mem[e_ff] <= rt_wd;
      if (er_we)  err_mem[e_ff]   <= er_wd;
      if (tr_we)  trunc_mem[e_ff] <= tr_wd;
      st_rd_ff <= state_mem[rd_addr];
      nx_rd_ff <= next_mem[rd_addr];
      pv_rd_ff <= prev_mem[rd_addr];
      ty_rd_ff <= type_mem[rd_addr];
      rl_rd_ff <= rlen_mem[rd_addr];
      rm_rd_ff <= rmax_mem[rd_addr];
      dl_rd_ff <= dlen_mem[rd_addr];
      tm_rd_ff <= time_mem[rd_addr];
      rt_rd_ff <= retry_mem[rd_addr];
      er_rd_ff <= err_mem[rd_addr];
      tr_rd_ff <= trunc_mem[rd_addr];
   end

endmodule
`default_nettype wire

// ===== rtl/rttr_checker.sv =====
`default_nettype none
`include "request_tag_tracker_timeout_retry_assert.svh"
module rttr_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_stall,
   input wire logic              rsp_valid,
   input wire logic              rsp_stall,
   input wire rttr_pkg::rsp_type rsp_data
);
   // a stalled result beat holds
   `RTTR_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
                     rsp_valid && $stable(rsp_data))
   // status codes stay in range
   `RTTR_ASSERT_NOW(a_status_range, clock, reset, rsp_valid,
                    rsp_data.status <= rttr_pkg::STATUS_RETRIED)
   // request fields only on issue outcomes
   `RTTR_ASSERT_NOW(a_issue_fields, clock, reset,
                    rsp_valid && rsp_data.status != rttr_pkg::STATUS_OK &&
                    rsp_data.status != rttr_pkg::STATUS_SEND_FAIL,
                    rsp_data.issued_type == '0 && rsp_data.out_request_length == '0)
   // nothing pending or blocked right after reset
   `RTTR_ASSERT_NOW(a_reset_clean, clock, reset, $past(reset),
                    !rsp_valid && !req_stall)
endmodule

bind request_tag_tracker_timeout_retry rttr_checker u_rttr_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
`default_nettype wire
